// ===== rtl/wavpk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavpk_pkg
// shared types, constants and the float conversion for the wav page packer
// ----------------------------------------------------------------------------
package wavpk_pkg;

    localparam int PAGE_BYTES      = 256;
    localparam int MAX_IN_CHANNELS = 8;
    localparam int FILL_W          = $clog2(PAGE_BYTES) + 1;
    localparam int QDEPTH          = 2;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_NOWAV  = 2'd2;
    localparam logic [1:0] KIND_BADFMT = 2'd3;

    localparam logic [0:0] REG_EMIT  = 1'd0;
    localparam logic [0:0] REG_FIRST = 1'd1;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE,
        PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_DONE
    } phase_t;

    // job kinds sent from the front end to the back end
    typedef enum logic [1:0] {
        JOB_VERDICT, JOB_HEADER, JOB_FRAME
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [1:0]  verdict;
        logic [31:0] rate;
        logic [31:0] size2;
        logic [19:0] sum;
        logic [31:0] frame;
        logic [15:0] chans;
        logic        last;
        logic        fresh;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_DIV, BK_FIX, BK_OUT
    } back_state_t;

    // ieee single times 32767, rounded to 24 bits nearest even, truncated, saturated
    function automatic logic signed [15:0] float_to_s16(input logic [31:0] b);
        logic [7:0]  e;
        logic [23:0] man;
        logic [38:0] p;
        logic [38:0] q;
        logic [38:0] rem;
        logic [38:0] half;
        logic        big;
        logic [20:0] mag;
        logic [38:0] shq;
        logic [8:0]  s;
        logic signed [15:0] r;
        e    = b[30:23];
        man  = {1'b1, b[22:0]};
        p    = 39'(man) * 39'd32767;
        big  = p[38];
        q    = big ? (p >> 15) : (p >> 14);
        rem  = big ? (p & 39'h7FFF) : (p & 39'h3FFF);
        half = big ? 39'h4000 : 39'h2000;
        if (rem > half || (rem == half && q[0])) q = q + 39'd1;
        q    = big ? (q << 15) : (q << 14);
        s    = 9'd150 - {1'b0, e};
        mag  = 21'd0;
        shq  = 39'd0;
        if (e == 8'hFF) begin
            mag = 21'h100000;
        end else if (e >= 8'd150) begin
            mag = 21'h100000;
        end else if (s < 9'd39) begin
            shq = q >> s;
            // anything past 21 bits saturates anyway
            mag = (shq[38:21] != 18'd0) ? 21'h100000 : shq[20:0];
        end
        if (e == 8'd0 || (e == 8'hFF && b[22:0] != 23'd0)) begin
            r = 16'sd0;
        end else if (b[31]) begin
            r = (mag > 21'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, mag}));
        end else begin
            r = (mag > 21'd32767) ? 16'sd32767 : 16'(mag);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/wav_to_mono16_page_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wav_to_mono16_page_packer
// parses a wav byte stream and emits header info and 16-bit mono samples
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_        in         file_byte, file_start
// m_        out        kind, mono_sample, page_address, flags, rate, length
// apb       in/out     emit_samples (0x0), first_page (0x4)
//
// the parser takes one byte per cycle while the job queue has room.
// header and sample jobs pass through the back end as pop, 32 divider
// steps, a fix state, output load; verdicts go straight to the load. the
// result shows in the cycle after the load. a two-entry job queue lets the
// parser run ahead; when full, s_ready drops until the back end pops a job.
// reset is synchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module wav_to_mono16_page_packer import wavpk_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:2]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic [7:0]  s_file_byte,
    input  wire logic        s_file_start,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic [1:0]       m_kind,
    output logic [15:0]      m_mono_sample,
    output logic [23:0]      m_page_address,
    output logic             m_page_done,
    output logic             m_stream_last,
    output logic [31:0]      m_rate_hz,
    output logic [31:0]      m_mono_length_bytes,
    output logic             m_valid,
    input  wire logic        m_ready
);

    logic        emit_reg;
    logic [23:0] first_reg;
    job_t        fjob, qjob;
    logic        push, qfull, qvalid, pop;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_FIRST) ? {8'd0, first_reg} : {31'd0, emit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg <= 1'b0; first_reg <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr == REG_EMIT) emit_reg <= pwdata[0];
            else first_reg <= pwdata[23:0];
        end
    end

    wavpk_front u_front (
        .aclk, .aresetn, .emit_samples(emit_reg), .s_file_byte, .s_file_start,
        .s_valid, .s_ready, .job(fjob), .job_push(push), .job_full(qfull)
    );

    wavpk_queue u_queue (
        .aclk, .aresetn, .wr_job(fjob), .wr_en(push), .full(qfull),
        .rd_job(qjob), .rd_valid(qvalid), .rd_en(pop)
    );

    wavpk_back u_back (
        .aclk, .aresetn,
        .first_page(first_reg), .job(qjob), .job_valid(qvalid), .job_pop(pop),
        .m_kind, .m_mono_sample, .m_page_address, .m_page_done, .m_stream_last,
        .m_rate_hz, .m_mono_length_bytes, .m_valid, .m_ready
    );

`ifndef SYNTHESIS
    a_pready: assert property (@(posedge aclk) pready) else $error("pready low");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !qfull |-> s_ready) else $error("stalled with room");
`endif

endmodule
`default_nettype wire

// ===== rtl/wavpk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavpk_front
// byte parser: tags, chunk walk, fmt fields, frame summing; emits jobs
// ----------------------------------------------------------------------------
module wavpk_front import wavpk_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        emit_samples,
    input  wire logic [7:0]  s_file_byte,
    input  wire logic        s_file_start,
    input  wire logic        s_valid,
    output logic             s_ready,
    output job_t             job,
    output logic             job_push,
    input  wire logic        job_full
);

    phase_t      phase_reg, phase_next;
    logic [31:0] field_reg, field_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    logic [31:0] rem_reg, rem_next;
    logic        odd_reg, odd_next;
    logic [5:0]  off_reg, off_next;
    logic        fmt_seen_reg, fmt_seen_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic [19:0] sum_reg, sum_next;
    logic [1:0]  ckind_reg, ckind_next;
    logic [2:0]  cbyte_reg, cbyte_next;
    logic [15:0] cidx_reg, cidx_next;
    logic [31:0] lane_reg, lane_next;
    logic        fresh_reg, fresh_next;
    logic [31:0] frame_reg;

    // frame size is a narrow product held in a register once the fmt fields settle
    always_ff @(posedge aclk) begin
        frame_reg <= 32'(bits_reg[15:3]) * 32'(chan_reg);
    end

    assign s_ready = !job_full;

    always_comb begin
        logic        restart;
        phase_t      ph;
        logic [31:0] fb;
        logic [2:0]  fc;
        logic [31:0] rm;
        logic [15:0] w;
        logic [31:0] wide;
        logic signed [15:0] v;
        logic [15:0] ci;
        logic [2:0]  cb;
        logic [31:0] ln;
        logic [19:0] sm;
        phase_next = phase_reg; field_next = field_reg; fcnt_next = fcnt_reg;
        rem_next = rem_reg; odd_next = odd_reg; off_next = off_reg;
        fmt_seen_next = fmt_seen_reg; chan_next = chan_reg; bits_next = bits_reg;
        rate_next = rate_reg; sum_next = sum_reg; ckind_next = ckind_reg;
        cbyte_next = cbyte_reg; cidx_next = cidx_reg; lane_next = lane_reg;
        fresh_next = fresh_reg;
        job = '0; job_push = 1'b0;
        restart = s_file_start;
        ph = restart ? PH_RIFF : phase_reg;
        fb = restart ? 32'd0 : field_reg;
        fc = restart ? 3'd0 : fcnt_reg;
        rm = restart ? 32'd0 : rem_reg;
        w  = 16'(bits_reg[15:3]);
        v  = 16'sd0;
        wide = 32'd0;
        ci = cidx_reg; cb = cbyte_reg; ln = lane_reg; sm = sum_reg;
        if (s_valid && s_ready) begin
            if (restart) begin
                phase_next = PH_RIFF; field_next = '0; fcnt_next = '0; rem_next = '0;
                odd_next = 1'b0; off_next = '0; fmt_seen_next = 1'b0; chan_next = '0;
                bits_next = '0; rate_next = '0; sum_next = '0; ckind_next = '0;
                cbyte_next = '0; cidx_next = '0; lane_next = '0;
                fresh_next = 1'b1;
                w = 16'd0;
            end
            wide = fb | (32'(s_file_byte) << {fc[1:0], 3'b000});
            unique case (ph)
                PH_RIFF, PH_WAVE, PH_RSIZE, PH_CID: begin
                    field_next = wide; fcnt_next = fc + 3'd1;
                    if (fc == 3'd3) begin
                        field_next = '0; fcnt_next = '0;
                        if (ph == PH_RSIZE) begin
                            phase_next = PH_WAVE;
                        end else if (ph == PH_CID) begin
                            ckind_next = (wide == TAG_FMT) ? 2'd1 :
                                         (wide == TAG_DATA) ? 2'd2 : 2'd0;
                            phase_next = PH_CSIZE;
                        end else if (wide != ((ph == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
                            phase_next = PH_DONE;
                            job.kind = JOB_VERDICT; job.verdict = KIND_NOWAV;
                            job_push = 1'b1;
                        end else begin
                            phase_next = (ph == PH_RIFF) ? PH_RSIZE : PH_CID;
                        end
                    end
                end
                PH_CSIZE: begin
                    field_next = wide; fcnt_next = fc + 3'd1;
                    if (fc == 3'd3) begin
                        field_next = '0; fcnt_next = '0;
                        rem_next = wide; odd_next = wide[0]; off_next = '0;
                        if (ckind_reg != 2'd2) begin
                            if (ckind_reg == 2'd1) fmt_seen_next = 1'b1;
                            if (wide == 32'd0) phase_next = wide[0] ? PH_PAD : PH_CID;
                            else phase_next = (ckind_reg == 2'd1) ? PH_FMT : PH_SKIP;
                        end else begin
                            phase_next = PH_DONE;
                            job_push = 1'b1;
                            if (!fmt_seen_reg || frame_reg == 32'd0 ||
                                (emit_samples && (chan_reg > 16'(MAX_IN_CHANNELS) ||
                                 w > 16'd4))) begin
                                job.kind = JOB_VERDICT; job.verdict = KIND_BADFMT;
                            end else begin
                                job.kind = JOB_HEADER; job.rate = rate_reg;
                                job.size2 = {wide[30:0], 1'b0}; job.frame = frame_reg;
                                if (emit_samples && wide != 32'd0) begin
                                    phase_next = PH_DATA;
                                    sum_next = '0; cbyte_next = '0; cidx_next = '0;
                                    lane_next = '0;
                                end
                            end
                        end
                    end
                end
                PH_FMT: begin
                    if (off_reg == 6'd2) chan_next[7:0] = s_file_byte;
                    if (off_reg == 6'd3) chan_next[15:8] = s_file_byte;
                    if (off_reg == 6'd4) rate_next[7:0] = s_file_byte;
                    if (off_reg == 6'd5) rate_next[15:8] = s_file_byte;
                    if (off_reg == 6'd6) rate_next[23:16] = s_file_byte;
                    if (off_reg == 6'd7) rate_next[31:24] = s_file_byte;
                    if (off_reg == 6'd14) bits_next[7:0] = s_file_byte;
                    if (off_reg == 6'd15) bits_next[15:8] = s_file_byte;
                    if (off_reg != 6'd63) off_next = off_reg + 6'd1;
                    rem_next = rm - 32'd1;
                    if (rem_next == 32'd0) phase_next = odd_reg ? PH_PAD : PH_CID;
                end
                PH_SKIP: begin
                    rem_next = rm - 32'd1;
                    if (rem_next == 32'd0) phase_next = odd_reg ? PH_PAD : PH_CID;
                end
                PH_PAD: phase_next = PH_CID;
                PH_DATA: begin
                    rem_next = rm - 32'd1;
                    ln = ln | (32'(s_file_byte) << {cb[1:0], 3'b000});
                    cb = cb + 3'd1;
                    if (16'(cb) >= w) begin
                        if (bits_reg == 16'd16) v = $signed(ln[15:0]);
                        else if (bits_reg == 16'd24) v = $signed(ln[23:8]);
                        else if (bits_reg == 16'd32) v = float_to_s16(ln);
                        sm = sm + 20'($signed(v));
                        ln = '0; cb = '0; ci = ci + 16'd1;
                    end
                    lane_next = ln; cbyte_next = cb; cidx_next = ci; sum_next = sm;
                    if (ci < chan_reg) begin
                        if (rem_next == 32'd0) phase_next = PH_DONE;
                    end else begin
                        sum_next = '0; cidx_next = '0;
                        job.kind = JOB_FRAME; job.sum = sm; job.chans = chan_reg;
                        job.last = rem_next < frame_reg;
                        job_push = 1'b1;
                        if (job.last) phase_next = PH_DONE;
                    end
                end
                default: ;
            endcase
            // first job of a new file tells the back end to restart page counting
            if (job_push) begin
                job.fresh = fresh_reg;
                fresh_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            fcnt_reg <= '0; field_reg <= '0; rem_reg <= '0; odd_reg <= 1'b0;
            off_reg <= '0; fmt_seen_reg <= 1'b0; chan_reg <= '0; bits_reg <= '0;
            rate_reg <= '0; sum_reg <= '0; ckind_reg <= '0; cbyte_reg <= '0;
            cidx_reg <= '0; lane_reg <= '0; fresh_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; field_reg <= field_next; fcnt_reg <= fcnt_next;
            rem_reg <= rem_next; odd_reg <= odd_next; off_reg <= off_next;
            fmt_seen_reg <= fmt_seen_next; chan_reg <= chan_next; bits_reg <= bits_next;
            rate_reg <= rate_next; sum_reg <= sum_next; ckind_reg <= ckind_next;
            cbyte_reg <= cbyte_next; cidx_reg <= cidx_next; lane_reg <= lane_next;
            fresh_reg <= fresh_next;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        job_full |-> !job_push) else $error("job pushed into full queue");
    a_idle_no_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE && !s_file_start) |-> !job_push)
        else $error("job while idle");
    a_fcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= 3'd3) else $error("field count out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/wavpk_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavpk_queue
// short job queue between parser and divider back end
// ----------------------------------------------------------------------------
module wavpk_queue import wavpk_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  job_t      wr_job,
    input  wire logic wr_en,
    output logic      full,
    output job_t      rd_job,
    output logic      rd_valid,
    input  wire logic rd_en
);

    localparam int AW = $clog2(QDEPTH);

    job_t          mem [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg, cnt_next;

    assign full     = cnt_reg == (AW+1)'(QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_job   = mem[rp_reg];

    always_comb begin
        cnt_next = cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= (wp_reg == AW'(QDEPTH-1)) ? '0 : wp_reg + AW'(1);
            if (rd_en) rp_reg <= (rp_reg == AW'(QDEPTH-1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> rd_valid) else $error("queue underflow");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !rd_en) |-> !full) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/wavpk_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavpk_back
// restoring divider, page tagging and output register
// ----------------------------------------------------------------------------
module wavpk_back import wavpk_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [23:0] first_page,
    input  job_t             job,
    input  wire logic        job_valid,
    output logic             job_pop,
    output logic [1:0]       m_kind,
    output logic [15:0]      m_mono_sample,
    output logic [23:0]      m_page_address,
    output logic             m_page_done,
    output logic             m_stream_last,
    output logic [31:0]      m_rate_hz,
    output logic [31:0]      m_mono_length_bytes,
    output logic             m_valid,
    input  wire logic        m_ready
);

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rmd_reg, rmd_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  step_reg, step_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [23:0] pages_reg, pages_next;
    logic        neg_reg, neg_next;
    logic        out_load;

    always_comb begin
        logic [32:0] trial;
        logic [19:0] absum;
        logic [FILL_W-1:0] nf;
        state_next = state_reg; job_next = job_reg; quo_next = quo_reg;
        rmd_next = rmd_reg; den_next = den_reg; step_next = step_reg;
        fill_next = fill_reg; pages_next = pages_reg; neg_next = neg_reg;
        job_pop = 1'b0; out_load = 1'b0;
        trial = '0; nf = '0;
        absum = job.sum[19] ? 20'(-job.sum) : job.sum;
        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    job_pop = 1'b1; job_next = job;
                    neg_next = job.sum[19];
                    rmd_next = '0; step_next = '0;
                    if (job.fresh) begin
                        fill_next = '0; pages_next = '0;
                    end
                    if (job.kind == JOB_VERDICT) begin
                        state_next = BK_OUT;
                    end else if (job.kind == JOB_HEADER) begin
                        quo_next = job.size2; den_next = job.frame;
                        state_next = BK_DIV;
                    end else begin
                        quo_next = 32'(absum); den_next = 32'(job.chans);
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV: begin
                // one quotient bit per cycle
                trial = {rmd_reg, quo_reg[31]} - {1'b0, den_reg};
                if (!trial[32]) begin
                    rmd_next = trial[31:0]; quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rmd_next = {rmd_reg[30:0], quo_reg[31]}; quo_next = {quo_reg[30:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd31) state_next = BK_FIX;
            end
            BK_FIX: state_next = BK_OUT;
            BK_OUT: begin
                if (!m_valid || m_ready) begin
                    out_load = 1'b1; state_next = BK_IDLE;
                    if (job_reg.kind == JOB_FRAME) begin
                        nf = fill_reg + FILL_W'(2);
                        if (nf >= FILL_W'(PAGE_BYTES)) begin
                            fill_next = '0; pages_next = pages_reg + 24'd1;
                        end else begin
                            fill_next = nf;
                        end
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE; fill_reg <= '0; pages_reg <= '0; m_valid <= 1'b0;
        end else begin
            state_reg <= state_next; fill_reg <= fill_next; pages_reg <= pages_next;
            if (out_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        logic [FILL_W-1:0] nf;
        job_reg <= job_next; quo_reg <= quo_next; rmd_reg <= rmd_next;
        den_reg <= den_next; step_reg <= step_next; neg_reg <= neg_next;
        nf = fill_reg + FILL_W'(2);
        if (out_load) begin
            m_kind <= KIND_SAMPLE; m_mono_sample <= '0; m_page_address <= '0;
            m_page_done <= 1'b0; m_stream_last <= 1'b0; m_rate_hz <= '0;
            m_mono_length_bytes <= '0;
            unique case (job_reg.kind)
                JOB_VERDICT: m_kind <= job_reg.verdict;
                JOB_HEADER: begin
                    m_kind <= KIND_HEADER; m_rate_hz <= job_reg.rate;
                    m_mono_length_bytes <= quo_reg;
                end
                JOB_FRAME: begin
                    m_mono_sample <= neg_reg ? 16'(-quo_reg) : quo_reg[15:0];
                    m_page_address <= first_page + pages_reg;
                    m_page_done <= job_reg.last || nf >= FILL_W'(PAGE_BYTES);
                    m_stream_last <= job_reg.last;
                end
                default: m_kind <= KIND_SAMPLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> state_reg == BK_IDLE) else $error("pop while busy");
    a_load_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid) else $error("result lost");
    a_fill_even: assert property (@(posedge aclk) disable iff (!aresetn)
        !fill_reg[0]) else $error("odd page fill");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav page packer testbench
// feeds generated wav files byte by byte, predicts header info, verdicts and
// mono samples in a scoreboard and compares every result in order
// ----------------------------------------------------------------------------
module testbench;
    import wavpk_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] mono;
        logic [23:0] page;
        logic        pdone;
        logic        slast;
        logic [31:0] rate;
        logic [31:0] mlen;
    } wav_result_t;

    class wav_scoreboard;
        bit          emit_on;
        bit [23:0]   first_pg;
        phase_t      ph;
        bit [31:0]   fbytes, remaining, rate_v, lane;
        int unsigned fcount, offset, chan_byte, chan_idx, fill;
        bit          odd, fmt_ok;
        bit [15:0]   chans, bits;
        int          fsum;
        bit [23:0]   pages;
        int unsigned ckind;
        wav_result_t expq[$];
        int          errors;

        function void clear();
            ph = PH_RIFF; fbytes = 0; fcount = 0; remaining = 0; odd = 0; offset = 0;
            fmt_ok = 0; chans = 0; bits = 0; rate_v = 0; fsum = 0; fill = 0;
            pages = 0; ckind = 0; chan_byte = 0; chan_idx = 0; lane = 0;
        endfunction

        function bit grab(bit [7:0] b);
            fbytes |= 32'(b) << (8 * (fcount % 4));
            fcount++;
            return fcount >= 4;
        endfunction

        function int f2s(bit [31:0] b);
            bit [7:0] e;
            longint unsigned p, q, rem, hf, mag;
            int unsigned d, sh;
            int k;
            e = b[30:23];
            if (e == 8'hFF) begin
                if (b[22:0] != 0) return 0;
                mag = 1 << 20;
            end else if (e == 0) begin
                return 0;
            end else begin
                p = longint'({1'b1, b[22:0]}) * 32767;
                d = (p >> 38) != 0 ? 15 : 14;
                q = p >> d; rem = p & ((64'd1 << d) - 1); hf = 64'd1 << (d - 1);
                k = int'(e) - 150;
                if (rem > hf || (rem == hf && q[0])) q++;
                q = q << d;
                if (k >= 0) mag = 1 << 20;
                else begin
                    sh = -k;
                    mag = sh >= 64 ? 0 : q >> sh;
                end
            end
            if (b[31]) return mag > 32768 ? -32768 : -int'(mag);
            return mag > 32767 ? 32767 : int'(mag);
        endfunction

        function void body_end();
            if (remaining == 0) ph = odd ? PH_PAD : PH_CID;
        endfunction

        function void push(logic [1:0] k, int m, bit [23:0] pg, bit pd, bit sl,
                           bit [31:0] r, bit [31:0] ml);
            wav_result_t x;
            x.kind = k; x.mono = 16'(m); x.page = pg; x.pdone = pd; x.slast = sl;
            x.rate = r; x.mlen = ml;
            expq.push_back(x);
        endfunction

        function void note_request(bit [7:0] b, bit start);
            bit [31:0] w, frame, want;
            int v, mono;
            bit last, full;
            if (start) clear();
            w = 32'(bits >> 3);
            frame = w * chans;
            case (ph)
                PH_RIFF, PH_WAVE: begin
                    if (grab(b)) begin
                        want = ph == PH_RIFF ? TAG_RIFF : TAG_WAVE;
                        fcount = 0;
                        if (fbytes != want) begin
                            ph = PH_DONE; fbytes = 0;
                            push(KIND_NOWAV, 0, 0, 0, 0, 0, 0);
                        end else begin
                            ph = ph == PH_RIFF ? PH_RSIZE : PH_CID;
                            fbytes = 0;
                        end
                    end
                end
                PH_RSIZE: if (grab(b)) begin
                    ph = PH_WAVE; fbytes = 0; fcount = 0;
                end
                PH_CID: if (grab(b)) begin
                    ckind = fbytes == TAG_FMT ? 1 : (fbytes == TAG_DATA ? 2 : 0);
                    ph = PH_CSIZE; fbytes = 0; fcount = 0;
                end
                PH_CSIZE: if (grab(b)) begin
                    remaining = fbytes; odd = fbytes[0]; offset = 0;
                    fbytes = 0; fcount = 0;
                    if (ckind == 1) begin
                        fmt_ok = 1; ph = PH_FMT; body_end();
                    end else if (ckind == 0) begin
                        ph = PH_SKIP; body_end();
                    end else begin
                        ph = PH_DONE;
                        if (!fmt_ok || frame == 0 || (emit_on &&
                            (chans > MAX_IN_CHANNELS || w > 4))) begin
                            push(KIND_BADFMT, 0, 0, 0, 0, 0, 0);
                        end else begin
                            push(KIND_HEADER, 0, 0, 0, 0, rate_v,
                                 (remaining * 2) / frame);
                            if (emit_on && remaining != 0) begin
                                ph = PH_DATA; fsum = 0; chan_byte = 0;
                                chan_idx = 0; lane = 0;
                            end
                        end
                    end
                end
                PH_FMT: begin
                    if (offset >= 2 && offset < 4) chans[8*(offset-2) +: 8] = b;
                    else if (offset >= 4 && offset < 8) rate_v[8*(offset-4) +: 8] = b;
                    else if (offset >= 14 && offset < 16) bits[8*(offset-14) +: 8] = b;
                    if (offset < 63) offset++;
                    remaining--;
                    body_end();
                end
                PH_SKIP: begin
                    remaining--;
                    body_end();
                end
                PH_PAD: ph = PH_CID;
                PH_DATA: begin
                    remaining--;
                    lane |= 32'(b) << (8 * (chan_byte % 4));
                    chan_byte++;
                    if (chan_byte >= w) begin
                        v = 0;
                        if (bits == 16) v = int'($signed(lane[15:0]));
                        else if (bits == 24) v = int'($signed(lane[23:8]));
                        else if (bits == 32) v = f2s(lane);
                        fsum += v;
                        lane = 0; chan_byte = 0; chan_idx++;
                    end
                    if (chan_idx < chans) begin
                        if (remaining == 0) ph = PH_DONE;
                    end else begin
                        mono = fsum / int'(chans);
                        fsum = 0; chan_idx = 0;
                        last = remaining < frame;
                        if (last) ph = PH_DONE;
                        fill += 2;
                        full = fill >= PAGE_BYTES;
                        push(KIND_SAMPLE, mono, first_pg + pages, full || last, last, 0, 0);
                        if (full) begin
                            fill = 0; pages++;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(wav_result_t a);
            wav_result_t e;
            if (expq.size() == 0) begin
                $display("%0t unexpected result kind %0d", $time, a.kind);
                errors++;
                return;
            end
            e = expq.pop_front();
            if (e != a) begin
                $display("%0t mismatch exp kind %0d mono %h page %h pd %b sl %b rate %h len %h",
                         $time, e.kind, e.mono, e.page, e.pdone, e.slast, e.rate, e.mlen);
                $display("%0t          got kind %0d mono %h page %h pd %b sl %b rate %h len %h",
                         $time, a.kind, a.mono, a.page, a.pdone, a.slast, a.rate, a.mlen);
                errors++;
            end
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        psel, penable, pwrite;
    logic [2:2]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic [7:0]  s_file_byte;
    logic        s_file_start, s_valid, s_ready;
    logic [1:0]  m_kind;
    logic [15:0] m_mono_sample;
    logic [23:0] m_page_address;
    logic        m_page_done, m_stream_last;
    logic [31:0] m_rate_hz, m_mono_length_bytes;
    logic        m_valid, m_ready;

    wav_scoreboard sb;
    int unsigned   cycles;
    int unsigned   sent;
    bit            calm;
    bit [7:0]      file_q[$];

    wav_to_mono16_page_packer u_top (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall bursts, none near the end
    initial begin
        int unsigned hold;
        wav_result_t r;
        m_ready = 0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                r.kind = m_kind; r.mono = m_mono_sample; r.page = m_page_address;
                r.pdone = m_page_done; r.slast = m_stream_last;
                r.rate = m_rate_hz; r.mlen = m_mono_length_bytes;
                sb.check_result(r);
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 11) - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    task automatic apb_write(input logic [2:2] a, input logic [31:0] d);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (a == REG_EMIT) sb.emit_on = d[0];
        else sb.first_pg = d[23:0];
        @(posedge aclk);
    endtask

    // valid stays up between back-to-back requests and drops only for idling
    task automatic send_byte(input bit [7:0] b, input bit start);
        if (!calm && $urandom_range(0, 6) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1; s_file_byte <= b; s_file_start <= start;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(b, start);
        sent++;
    endtask

    task automatic send_file();
        bit first;
        first = 1;
        while (file_q.size() > 0) begin
            send_byte(file_q.pop_front(), first);
            first = 0;
        end
    endtask

    task automatic put32(input bit [31:0] v);
        for (int i = 0; i < 4; i++) file_q.push_back(v[8*i +: 8]);
    endtask

    // builds a file: riff, optional junk chunk, optional fmt, data with random frames
    task automatic build_wav(input bit [15:0] ch, input bit [15:0] bps, input int nbytes,
                             input int fmt_len, input bit junk, input bit bad_tag,
                             input bit no_fmt, input int fmode);
        bit [31:0] v;
        put32(bad_tag && $urandom_range(0, 1) ? $urandom : TAG_RIFF);
        put32($urandom);
        put32(bad_tag ? $urandom : TAG_WAVE);
        if (junk) begin
            v = $urandom_range(0, 5);
            put32(32'h6b6e756a); put32(v);
            for (int i = 0; i < v; i++) file_q.push_back($urandom);
            if (v[0]) file_q.push_back($urandom);
        end
        if (!no_fmt) begin
            put32(TAG_FMT); put32(fmt_len);
            for (int i = 0; i < fmt_len; i++) begin
                case (i)
                    2: v = ch[7:0];
                    3: v = ch[15:8];
                    4, 5, 6, 7: v = $urandom;
                    14: v = bps[7:0];
                    15: v = bps[15:8];
                    default: v = $urandom;
                endcase
                file_q.push_back(v[7:0]);
            end
            if (fmt_len % 2) file_q.push_back($urandom);
        end
        put32(TAG_DATA); put32(nbytes);
        for (int i = 0; i < nbytes; i++) begin
            if (bps == 32 && i % 4 == 3 && fmode != 0)
                v = fmode == 1 ? ($urandom_range(0, 1) ? 8'h7F : 8'hFF)
                               : ($urandom_range(0, 1) ? 8'h3F : 8'hBF);
            else if (bps == 32 && i % 4 == 2 && fmode == 2)
                v = $urandom_range(0, 1) ? 8'h80 : $urandom;
            else
                v = $urandom;
            file_q.push_back(v[7:0]);
        end
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.expq.size() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    initial begin
        bit [15:0] ch, bps;
        int n;
        sb = new();
        sb.clear();
        sb.ph = PH_IDLE;
        cycles = 0; sent = 0; calm = 0;
        aresetn = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_valid = 0; s_file_byte = 0; s_file_start = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: header only, then errors, then each depth
        send_byte(8'hA5, 0);
        build_wav(2, 16, 8, 16, 0, 0, 0, 0); send_file();
        build_wav(1, 16, 4, 16, 0, 1, 0, 0); send_file();
        build_wav(1, 16, 4, 16, 0, 0, 1, 0); send_file();
        build_wav(0, 16, 4, 16, 0, 0, 0, 0); send_file();
        build_wav(1, 16, 4, 4, 1, 0, 0, 0); send_file();
        build_wav(1, 16, 32'h8000_0001, 16, 0, 0, 0, 0); send_file();
        drain();
        apb_write(REG_EMIT, 1);
        apb_write(REG_FIRST, 24'hFFFFFF);
        build_wav(9, 16, 4, 16, 0, 0, 0, 0); send_file();
        build_wav(1, 40, 4, 16, 0, 0, 0, 0); send_file();
        build_wav(1, 16, 0, 16, 0, 0, 0, 0); send_file();
        build_wav(2, 16, 9, 16, 1, 0, 0, 0); send_file();
        build_wav(3, 24, 18, 18, 0, 0, 0, 0); send_file();
        build_wav(8, 32, 32, 16, 0, 0, 0, 1); send_file();
        build_wav(1, 32, 16, 16, 0, 0, 0, 2); send_file();
        drain();

        // random files, a few settings between phases
        for (int ph = 0; ph < 4; ph++) begin
            apb_write(REG_EMIT, ph != 1);
            apb_write(REG_FIRST, ph == 2 ? 24'd0 : (ph == 3 ? 24'hFFFFFE : $urandom));
            if (ph == 3) begin
                calm = 1;
                // one full page and a partial one at one byte per frame
                build_wav(1, 8, 132, 16, 0, 0, 0, 0); send_file();
            end
            ch = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 8);
            case ($urandom_range(0, 5))
                0: bps = $urandom;
                1: bps = 24;
                2: bps = 32;
                default: bps = 16;
            endcase
            n = $urandom_range(0, 16);
            build_wav(ch, bps, n, $urandom_range(0, 9) == 0 ? $urandom_range(0, 20) : 16,
                      $urandom_range(0, 2) == 0, $urandom_range(0, 15) == 0,
                      $urandom_range(0, 20) == 0, $urandom_range(0, 2));
            if ($urandom_range(0, 4) == 0) file_q.push_back($urandom);
            send_file();
            drain();
        end

        if (sb.errors == 0 && sb.expq.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
